@@ sv/slbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_pkg
// Types, character codes and sizes shared by the serial LED blink controller.
// ----------------------------------------------------------------------------
package slbc_pkg;

  localparam int COUNT_WIDTH  = 20;
  localparam int PERIOD_WIDTH = 20;
  localparam int NUM_PERIODS  = 5;
  localparam int CHOICE_WIDTH = $clog2(NUM_PERIODS);
  localparam int CMP_WIDTH    =
    ((COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH) + 1;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_WIDTH    = $clog2(FIFO_DEPTH);
  localparam int FILL_WIDTH   = $clog2(FIFO_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [PERIOD_WIDTH-1:0] period_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [CHOICE_WIDTH-1:0] choice_t;
  typedef logic [CHOICE_WIDTH-1:0] reg_index_t;

  localparam period_t PERIOD_RESET [NUM_PERIODS] = '{
    PERIOD_WIDTH'(50), PERIOD_WIDTH'(100), PERIOD_WIDTH'(200),
    PERIOD_WIDTH'(500), PERIOD_WIDTH'(1000)
  };

  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_FIVE    = 8'h35;
  localparam logic [7:0] CH_STEADY  = 8'h73;
  localparam logic [7:0] CH_DARK    = 8'h65;
  localparam logic [7:0] CH_HELLO   = 8'h68;
  localparam logic [7:0] CH_BYE     = 8'h62;
  localparam logic [7:0] CH_ACK     = 8'h61;
  localparam logic [7:0] CH_UNKNOWN = 8'h75;
  localparam logic [7:0] CH_LED_ON  = 8'h78;
  localparam logic [7:0] CH_LED_OFF = 8'h6F;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       led_level;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage
`default_nettype wire

@@ sv/slbc_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_item_if
// Input item channel: a received byte or one time tick.
// ----------------------------------------------------------------------------
interface slbc_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ sv/slbc_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_result_if
// Result channel: one character to send with the LED level.
// ----------------------------------------------------------------------------
interface slbc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       led_level;
  logic       last;

  modport source (output valid, output tx_byte, output led_level, output last,
                  input ready);
  modport sink (input valid, input tx_byte, input led_level, input last,
                output ready);
endinterface
`default_nettype wire

@@ sv/slbc_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_cfg_if
// Configuration write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface slbc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [slbc_pkg::CHOICE_WIDTH-1:0]   reg_index;
  logic [slbc_pkg::PERIOD_WIDTH-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

@@ sv/serial_led_blink_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result passes the input register and the result queue before it is taken.
// Throughput: one item per cycle while the queue has room; an item with two
// results sends both, buffered by a four-entry result queue.
// Input stalls only when fewer than two queue entries are free.
// Reset clears the LED state, the queue and restores the default periods.
// ----------------------------------------------------------------------------
// serial_led_blink_controller
// LED controller driven by command bytes and time ticks, with status reports.
// ----------------------------------------------------------------------------
module serial_led_blink_controller
  import slbc_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  slbc_item_if.sink     item_i,
  slbc_result_if.source result_o,
  slbc_cfg_if.sink      cfg_i
);

  period_t periods [NUM_PERIODS];
  push_t   push;
  logic    space_ok;

  slbc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .periods_o (periods)
  );

  slbc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .periods_i  (periods),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  slbc_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire

@@ sv/slbc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_cfg_regs
// The five blink half-period registers and their write port.
// ----------------------------------------------------------------------------
module slbc_cfg_regs
  import slbc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  slbc_cfg_if.sink   cfg_i,
  output period_t    periods_o [NUM_PERIODS]
);

  period_t periods_q [NUM_PERIODS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q <= PERIOD_RESET;
    end else if (cfg_i.valid && (32'(cfg_i.reg_index) < NUM_PERIODS)) begin
      periods_q[cfg_i.reg_index] <= cfg_i.wdata;
    end
  end

  assign periods_o = periods_q;

endmodule
`default_nettype wire

@@ sv/slbc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_core
// Input register and the combinational command and tick update of the LED state.
// ----------------------------------------------------------------------------
module slbc_core
  import slbc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  slbc_item_if.sink  item_i,
  input  period_t    periods_i [NUM_PERIODS],
  input  logic       space_ok_i,
  output push_t      push_o
);

  logic       in_valid_q;
  logic       cmd_q;
  logic [7:0] byte_q;

  logic    led_q, led_d;
  mode_e   mode_q, mode_d;
  logic    reported_q, reported_d;
  count_t  tick_q, tick_d;
  choice_t choice_q, choice_d;
  logic    finished_q, finished_d;

  logic                 advance;
  choice_t              choice_sel;
  logic [CMP_WIDTH-1:0] period_ext;
  logic [CMP_WIDTH-1:0] period_lim;
  count_t               tick_sum;
  logic                 is_bye;
  logic                 report;
  logic [7:0]           answer;
  result_t              status;

  assign advance     = in_valid_q && space_ok_i;
  assign item_i.ready = !in_valid_q || space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      cmd_q  <= item_i.command;
      byte_q <= item_i.rx_byte;
    end
  end

  // Out-of-range selections fall back to the first period; the period is
  // clamped to what the counter can hold.
  assign choice_sel = (32'(choice_q) < NUM_PERIODS) ? choice_q : '0;
  assign period_ext = CMP_WIDTH'(periods_i[choice_sel]);
  assign period_lim = (period_ext > CMP_WIDTH'(COUNT_MAX)) ?
                      CMP_WIDTH'(COUNT_MAX) : period_ext;
  assign tick_sum   = tick_q + count_t'(1);

  always_comb begin
    led_d      = led_q;
    mode_d     = mode_q;
    reported_d = reported_q;
    tick_d     = tick_q;
    choice_d   = choice_q;
    finished_d = finished_q;
    is_bye     = 1'b0;
    answer     = CH_UNKNOWN;
    if (advance && !finished_q) begin
      if (cmd_q) begin
        if (mode_q == MODE_BLINK) begin
          if (CMP_WIDTH'(tick_sum) >= period_lim) begin
            led_d  = !led_q;
            tick_d = '0;
          end else begin
            tick_d = tick_sum;
          end
        end
      end else begin
        unique case (byte_q) inside
          [CH_ONE:CH_FIVE]: begin
            choice_d = choice_t'(byte_q - CH_ONE);
            tick_d   = '0;
            mode_d   = MODE_BLINK;
            answer   = CH_ACK;
          end
          CH_STEADY: begin
            led_d  = 1'b1;
            mode_d = MODE_ON;
            answer = CH_ACK;
          end
          CH_DARK: begin
            led_d  = 1'b0;
            mode_d = MODE_OFF;
            answer = CH_ACK;
          end
          CH_HELLO: begin
            answer = CH_HELLO;
          end
          CH_BYE: begin
            led_d      = 1'b0;
            finished_d = 1'b1;
            is_bye     = 1'b1;
            answer     = CH_BYE;
          end
          default: begin
            answer = CH_UNKNOWN;
          end
        endcase
      end
    end
    report = advance && !finished_q && !is_bye && (mode_d == MODE_BLINK) &&
             (led_d != reported_q);
    if (report) begin
      reported_d = led_d;
    end
  end

  always_comb begin
    status.tx_byte   = led_d ? CH_LED_ON : CH_LED_OFF;
    status.led_level = led_d;
    status.last      = 1'b1;
    push_o.count     = 2'd0;
    push_o.first     = status;
    push_o.second    = status;
    if (advance && !finished_q) begin
      if (cmd_q) begin
        push_o.count = report ? 2'd1 : 2'd0;
      end else begin
        push_o.first.tx_byte   = answer;
        push_o.first.led_level = led_d;
        push_o.first.last      = !report;
        push_o.count           = report ? 2'd2 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q      <= 1'b0;
      mode_q     <= MODE_OFF;
      reported_q <= 1'b0;
      tick_q     <= '0;
      choice_q   <= '0;
      finished_q <= 1'b0;
    end else begin
      led_q      <= led_d;
      mode_q     <= mode_d;
      reported_q <= reported_d;
      tick_q     <= tick_d;
      choice_q   <= choice_d;
      finished_q <= finished_d;
    end
  end

  a_finished_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("finished flag cleared");

  a_no_result_when_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (push_o.count == 2'd0))
    else $error("result produced after finish");

  a_led_off_after_bye: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_bye) |=> (!led_q && finished_q))
    else $error("bye did not turn the LED off");

  a_report_tracks_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report |=> (reported_q == led_q))
    else $error("reported level differs from LED after a status report");

endmodule
`default_nettype wire

@@ sv/slbc_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbc_out_fifo
// Result queue taking up to two results per cycle and sending one per cycle while ready.
// ----------------------------------------------------------------------------
module slbc_out_fifo
  import slbc_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  push_t        push_i,
  output logic         space_ok_o,
  slbc_result_if.source result_o
);

  result_t                mem_q [FIFO_DEPTH];
  logic [PTR_WIDTH-1:0]   wr_q, wr_d;
  logic [PTR_WIDTH-1:0]   rd_q, rd_d;
  logic [FILL_WIDTH-1:0]  fill_q, fill_d;
  logic [PTR_WIDTH-1:0]   wr_next;
  logic                   pop;

  assign wr_next    = wr_q + PTR_WIDTH'(1);
  assign pop        = result_o.valid && result_o.ready;
  assign space_ok_o = (32'(fill_q) <= FIFO_DEPTH - 2);

  assign result_o.valid     = (fill_q != '0);
  assign result_o.tx_byte   = mem_q[rd_q].tx_byte;
  assign result_o.led_level = mem_q[rd_q].led_level;
  assign result_o.last      = mem_q[rd_q].last;

  always_comb begin
    wr_d   = wr_q + PTR_WIDTH'(push_i.count);
    rd_d   = pop ? (rd_q + PTR_WIDTH'(1)) : rd_q;
    fill_d = fill_q + FILL_WIDTH'(push_i.count) - FILL_WIDTH'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> space_ok_o)
    else $error("result pushed without room");

  a_fill_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PTR_WIDTH'(wr_q - rd_q) == PTR_WIDTH'(fill_q)))
    else $error("fill count out of step with pointers");

endmodule
`default_nettype wire

@@ sim/tb_serial_led_blink_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_led_blink_controller
// Self-checking testbench for the serial LED blink controller. A scoreboard
// keeps its own copy of the LED state and periods, predicts the answers and
// status reports of every transferred byte or tick, and compares them with
// the result channel. Both channels idle and stall at random, and the period
// registers are rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_serial_led_blink_controller;
  import slbc_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 1500000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam reg_index_t REG_PERIOD_ONE   = 3'd0;
  localparam reg_index_t REG_PERIOD_TWO   = 3'd1;
  localparam reg_index_t REG_PERIOD_THREE = 3'd2;
  localparam reg_index_t REG_PERIOD_FOUR  = 3'd3;
  localparam reg_index_t REG_PERIOD_FIVE  = 3'd4;
  localparam reg_index_t REG_INDEX_TOP    = 3'd7;

  localparam period_t PERIOD_TOP      = '1;
  localparam period_t PERIOD_RANGE_HI = 20'd1000000;

  class led_scoreboard;
    period_t  periods [NUM_PERIODS];
    logic     led_on;
    mode_e    mode;
    logic     reported;
    count_t   ticks;
    choice_t  choice;
    logic     finished;
    result_t  expected_tx [$];
    int       errors;
    int       n_items;
    int       n_results;
    int       n_reports;

    function new();
      periods[0] = 20'd50;
      periods[1] = 20'd100;
      periods[2] = 20'd200;
      periods[3] = 20'd500;
      periods[4] = 20'd1000;
      led_on    = 1'b0;
      mode      = MODE_OFF;
      reported  = 1'b0;
      ticks     = '0;
      choice    = '0;
      finished  = 1'b0;
      errors    = 0;
      n_items   = 0;
      n_results = 0;
      n_reports = 0;
    endfunction

    function void write_period(reg_index_t idx, period_t value);
      if (idx < NUM_PERIODS) begin
        periods[idx] = value;
      end
    endfunction

    function void take_item(logic cmd, logic [7:0] rx);
      result_t    outs [2];
      int         n;
      period_t    limit;
      logic [7:0] answer;
      n = 0;
      n_items++;
      if (finished) begin
        return;
      end
      if (cmd == CMD_TICK) begin
        if (mode != MODE_BLINK) begin
          return;
        end
        limit = periods[(choice < NUM_PERIODS) ? choice : choice_t'(0)];
        ticks = ticks + 1'b1;
        if (ticks >= limit) begin
          led_on = ~led_on;
          ticks  = '0;
        end
      end else begin
        if (rx >= CH_ONE && rx <= CH_FIVE) begin
          choice = choice_t'(rx - CH_ONE);
          ticks  = '0;
          mode   = MODE_BLINK;
          answer = CH_ACK;
        end else if (rx == CH_STEADY) begin
          led_on = 1'b1;
          mode   = MODE_ON;
          answer = CH_ACK;
        end else if (rx == CH_DARK) begin
          led_on = 1'b0;
          mode   = MODE_OFF;
          answer = CH_ACK;
        end else if (rx == CH_HELLO) begin
          answer = CH_HELLO;
        end else if (rx == CH_BYE) begin
          led_on   = 1'b0;
          finished = 1'b1;
          expected_tx.push_back('{tx_byte: CH_BYE, led_level: 1'b0, last: 1'b1});
          return;
        end else begin
          answer = CH_UNKNOWN;
        end
        outs[n] = '{tx_byte: answer, led_level: led_on, last: 1'b0};
        n++;
      end
      if (mode == MODE_BLINK && led_on != reported) begin
        outs[n] = '{tx_byte: led_on ? CH_LED_ON : CH_LED_OFF, led_level: led_on,
                    last: 1'b0};
        reported = led_on;
        n++;
      end
      if (n > 0) begin
        outs[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        expected_tx.push_back(outs[i]);
      end
    endfunction

    task check_result(result_t got);
      result_t want;
      n_results++;
      if (expected_tx.size() == 0) begin
        report($sformatf("result %0d arrived with none expected, tx_byte %02h",
                         n_results, got.tx_byte));
        return;
      end
      want = expected_tx.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        report($sformatf("result %0d tx_byte %02h, expected %02h",
                         n_results, got.tx_byte, want.tx_byte));
      end
      if (got.led_level !== want.led_level) begin
        report($sformatf("result %0d led_level %b, expected %b",
                         n_results, got.led_level, want.led_level));
      end
      if (got.last !== want.last) begin
        report($sformatf("result %0d last %b, expected %b",
                         n_results, got.last, want.last));
      end
      if (want.tx_byte == CH_LED_ON || want.tx_byte == CH_LED_OFF) begin
        n_reports++;
      end
    endtask

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function int pending();
      return expected_tx.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  int   cycles;
  int   n_cfg;
  int unsigned stall_left;
  logic        ready_state;

  led_scoreboard sb = new();

  slbc_item_if   item_bus ();
  slbc_result_if result_bus ();
  slbc_cfg_if    cfg_bus ();

  serial_led_blink_controller i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               sb.pending());
      $display("serial_led_blink_controller: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        sb.check_result('{tx_byte: result_bus.tx_byte, led_level: result_bus.led_level,
                          last: result_bus.last});
      end
      if (item_bus.valid && item_bus.ready) begin
        sb.take_item(item_bus.command, item_bus.rx_byte);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_period(cfg_bus.reg_index, cfg_bus.wdata);
        n_cfg++;
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned r;
    if (stall_left != 0) begin
      stall_left--;
    end else if (calm) begin
      ready_state = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        ready_state = 1'b1;
        stall_left  = $urandom_range(0, 6);
      end else if (r < 95) begin
        ready_state = 1'b0;
        stall_left  = $urandom_range(0, 2);
      end else begin
        ready_state = 1'b0;
        stall_left  = $urandom_range(10, 40);
      end
    end
    result_bus.ready <= ready_state;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic cmd, logic [7:0] rx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid   <= 1'b1;
    item_bus.command <= cmd;
    item_bus.rx_byte <= rx;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_index_t idx, period_t value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drains the result channel and lets in-flight items settle before any
  // register write.
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_random(int count, int tick_pct, int digit_pct);
    int unsigned r;
    logic        cmd;
    logic [7:0]  rx;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      r  = $urandom_range(0, 99);
      rx = 8'($urandom_range(0, 255));
      cmd = CMD_BYTE;
      if (r < tick_pct) begin
        cmd = CMD_TICK;
      end else if (r < tick_pct + digit_pct) begin
        rx = 8'(CH_ONE + $urandom_range(0, NUM_PERIODS - 1));
      end else begin
        case ($urandom_range(0, 3))
          0: rx = CH_STEADY;
          1: rx = CH_DARK;
          2: rx = CH_HELLO;
          default: begin
            if (rx == CH_BYE) begin
              rx = CH_UNKNOWN;
            end
          end
        endcase
      end
      send_item(cmd, rx);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    calm              = 1'b0;
    cycles            = 0;
    n_cfg             = 0;
    stall_left        = 0;
    ready_state       = 1'b1;
    item_bus.valid    = 1'b0;
    item_bus.command  = CMD_BYTE;
    item_bus.rx_byte  = 8'h00;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = REG_PERIOD_ONE;
    cfg_bus.wdata     = '0;
    result_bus.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default periods: answers, steady modes, ignored ticks, blink start.
    send_item(CMD_BYTE, CH_HELLO);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, CH_ONE - 8'd1);
    send_item(CMD_BYTE, CH_FIVE + 8'd1);
    send_item(CMD_BYTE, CH_STEADY);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BYTE, CH_DARK);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, CH_STEADY);
    send_item(CMD_BYTE, CH_ONE);
    send_item(CMD_BYTE, CH_DARK);
    send_item(CMD_BYTE, CH_ONE + 8'd1);
    send_random(300, 90, 2);
    settle();

    write_reg(REG_PERIOD_ONE, '0);
    write_reg(REG_PERIOD_TWO, 20'd1);
    write_reg(REG_PERIOD_THREE, 20'd2);
    write_reg(REG_PERIOD_FOUR, 20'd3);
    write_reg(REG_PERIOD_FIVE, 20'd7);
    for (int i = NUM_PERIODS; i <= REG_INDEX_TOP; i++) begin
      write_reg(reg_index_t'(i), (i == NUM_PERIODS) ? PERIOD_TOP : period_t'(0));
    end
    cfg_bus.valid <= 1'b0;

    // Zero period toggles on every tick; out-of-range writes changed nothing.
    send_item(CMD_BYTE, CH_ONE);
    send_item(CMD_TICK, 8'h5A);
    send_item(CMD_TICK, 8'hA5);
    send_item(CMD_BYTE, CH_HELLO);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, CH_FIVE);
    send_item(CMD_BYTE, CH_STEADY);
    send_item(CMD_BYTE, CH_FIVE);
    send_random(800, 60, 15);
    settle();

    write_reg(REG_PERIOD_ONE, 20'($urandom_range(1, 20)));
    write_reg(REG_PERIOD_TWO, 20'($urandom_range(1, 20)));
    write_reg(REG_PERIOD_THREE, 20'($urandom_range(1, 20)));
    write_reg(REG_PERIOD_FOUR, PERIOD_TOP);
    write_reg(REG_PERIOD_FIVE, PERIOD_RANGE_HI);
    cfg_bus.valid <= 1'b0;
    send_random(600, 60, 12);
    settle();

    write_reg(REG_PERIOD_ONE, 20'($urandom_range(0, 40)));
    write_reg(REG_PERIOD_TWO, 20'($urandom_range(0, 40)));
    write_reg(REG_PERIOD_THREE, 20'($urandom_range(0, 40)));
    write_reg(REG_PERIOD_FOUR, 20'($urandom_range(0, 40)));
    write_reg(REG_PERIOD_FIVE, 20'($urandom_range(0, 40)));
    cfg_bus.valid <= 1'b0;
    send_random(150, 70, 10);

    // Finish while blinking with the LED lit; everything after is ignored.
    send_item(CMD_BYTE, CH_STEADY);
    send_item(CMD_BYTE, CH_ONE);
    send_item(CMD_BYTE, CH_BYE);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, CH_HELLO);
    send_item(CMD_BYTE, CH_ONE);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BYTE, CH_BYE);
    item_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d item transfers and %0d register writes across four period sets.",
             sb.n_items, n_cfg);
    $display("Checked %0d results, %0d of them LED status reports, with %0d errors.",
             sb.n_results, sb.n_reports, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("serial_led_blink_controller: match");
    end else begin
      $display("serial_led_blink_controller: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/slbc_pkg.sv
sv/slbc_item_if.sv
sv/slbc_result_if.sv
sv/slbc_cfg_if.sv
sv/slbc_cfg_regs.sv
sv/slbc_core.sv
sv/slbc_out_fifo.sv
sv/serial_led_blink_controller.sv
sim/tb_serial_led_blink_controller.sv
